// ===== rtl/pae_pkg.sv =====
`default_nettype none
package pae_pkg;

    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MD_APPEND = 3'd0,
        MD_INSERT = 3'd1,
        MD_DELETE = 3'd2,
        MD_REVERSE = 3'd3,
        MD_UPDATE = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_MODE  = 3'd1,
        ST_POS   = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_REV_RA,
        S_REV_RB,
        S_REV_WA,
        S_REV_WB,
        S_LIST,
        S_STAT
    } t_state;

    // memory address sources
    typedef enum logic [2:0] {
        AS_I,
        AS_IM1,
        AS_IP1,
        AS_J,
        AS_USED,
        AS_POS
    } t_asel;

    typedef enum logic [1:0] {
        DS_VAL,
        DS_RDATA,
        DS_HOLD
    } t_dsel;

    typedef enum logic [2:0] {
        PO_HOLD,
        PO_USED,
        PO_POS,
        PO_ZERO,
        PO_INC,
        PO_DEC
    } t_pop;

    typedef struct packed {
        logic    cap;
        logic    rd_en;
        t_asel   rd_sel;
        logic    wr_en;
        t_asel   wr_sel;
        t_dsel   wr_dsel;
        t_pop    i_op;
        logic    j_init;
        logic    j_dec;
        logic    hold_ld;
        logic    used_inc;
        logic    used_dec;
        logic    list_start;
        logic    list_run;
        logic    stat_ld;
        t_status stat_code;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic full;
        logic empty;
        logic pos_gt_used;
        logic pos_ge_used;
        logic i_gt_pos;
        logic ip1_lt_used;
        logic i_lt_j;
        logic out_free;
        logic list_done;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/pae_ctrl.sv =====
`default_nettype none
module pae_ctrl
    import pae_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state  r_state, n_state;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_code           = r_code;
        o_stall          = (r_state != S_IDLE);
        o_cmd.cap        = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = AS_I;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_sel     = AS_I;
        o_cmd.wr_dsel    = DS_VAL;
        o_cmd.i_op       = PO_HOLD;
        o_cmd.j_init     = 1'b0;
        o_cmd.j_dec      = 1'b0;
        o_cmd.hold_ld    = 1'b0;
        o_cmd.used_inc   = 1'b0;
        o_cmd.used_dec   = 1'b0;
        o_cmd.list_start = 1'b0;
        o_cmd.list_run   = 1'b0;
        o_cmd.stat_ld    = 1'b0;
        o_cmd.stat_code  = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.mode)
                    MD_APPEND: begin
                        if (i_sts.full) begin
                            n_code  = ST_FULL;
                            n_state = S_STAT;
                        end else begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.wr_sel   = AS_USED;
                            o_cmd.wr_dsel  = DS_VAL;
                            o_cmd.used_inc = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    MD_INSERT: begin
                        if (i_sts.full) begin
                            n_code  = ST_FULL;
                            n_state = S_STAT;
                        end else if (i_sts.pos_gt_used) begin
                            n_code  = ST_POS;
                            n_state = S_STAT;
                        end else begin
                            o_cmd.i_op = PO_USED;
                            n_state    = S_INS_RD;
                        end
                    end
                    MD_DELETE: begin
                        if (i_sts.empty) begin
                            n_code  = ST_EMPTY;
                            n_state = S_STAT;
                        end else if (i_sts.pos_ge_used) begin
                            n_code  = ST_POS;
                            n_state = S_STAT;
                        end else begin
                            o_cmd.i_op = PO_POS;
                            n_state    = S_DEL_RD;
                        end
                    end
                    MD_REVERSE: begin
                        if (i_sts.empty) begin
                            n_code  = ST_EMPTY;
                            n_state = S_STAT;
                        end else begin
                            o_cmd.i_op   = PO_ZERO;
                            o_cmd.j_init = 1'b1;
                            n_state      = S_REV_RA;
                        end
                    end
                    MD_UPDATE: begin
                        if (i_sts.empty) begin
                            n_code  = ST_EMPTY;
                            n_state = S_STAT;
                        end else if (i_sts.pos_ge_used) begin
                            n_code  = ST_POS;
                            n_state = S_STAT;
                        end else begin
                            o_cmd.wr_en      = 1'b1;
                            o_cmd.wr_sel     = AS_POS;
                            o_cmd.wr_dsel    = DS_VAL;
                            o_cmd.list_start = 1'b1;
                            n_state          = S_LIST;
                        end
                    end
                    default: begin
                        n_code  = ST_MODE;
                        n_state = S_STAT;
                    end
                endcase
            end
            S_INS_RD: begin
                if (i_sts.i_gt_pos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = AS_IM1;
                    n_state      = S_INS_WR;
                end else begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_sel     = AS_POS;
                    o_cmd.wr_dsel    = DS_VAL;
                    o_cmd.used_inc   = 1'b1;
                    o_cmd.list_start = 1'b1;
                    n_state          = S_LIST;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = AS_I;
                o_cmd.wr_dsel = DS_RDATA;
                o_cmd.i_op    = PO_DEC;
                n_state       = S_INS_RD;
            end
            S_DEL_RD: begin
                if (i_sts.ip1_lt_used) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = AS_IP1;
                    n_state      = S_DEL_WR;
                end else begin
                    o_cmd.used_dec   = 1'b1;
                    o_cmd.list_start = 1'b1;
                    n_state          = S_LIST;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = AS_I;
                o_cmd.wr_dsel = DS_RDATA;
                o_cmd.i_op    = PO_INC;
                n_state       = S_DEL_RD;
            end
            S_REV_RA: begin
                if (i_sts.i_lt_j) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = AS_I;
                    n_state      = S_REV_RB;
                end else begin
                    o_cmd.list_start = 1'b1;
                    n_state          = S_LIST;
                end
            end
            S_REV_RB: begin
                // keep the low word while the high one is read
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = AS_J;
                o_cmd.hold_ld = 1'b1;
                n_state       = S_REV_WA;
            end
            S_REV_WA: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = AS_I;
                o_cmd.wr_dsel = DS_RDATA;
                n_state       = S_REV_WB;
            end
            S_REV_WB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = AS_J;
                o_cmd.wr_dsel = DS_HOLD;
                o_cmd.i_op    = PO_INC;
                o_cmd.j_dec   = 1'b1;
                n_state       = S_REV_RA;
            end
            S_LIST: begin
                o_cmd.list_run = 1'b1;
                if (i_sts.list_done) begin
                    n_state = S_IDLE;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.stat_ld = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/pae_datapath.sv =====
`default_nettype none
module pae_datapath
    import pae_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cmd                       i_cmd,
    output t_sts                            o_sts,
    input  wire logic [MODE_W-1:0]          i_mode,
    input  wire logic [POS_W-1:0]           i_position,
    input  wire logic signed [WORD_W-1:0]   i_value,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [INDEX_W-1:0]              o_index,
    output logic signed [WORD_W-1:0]        o_element,
    output logic                            o_last,
    output logic [STATUS_W-1:0]             o_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic [WORD_W-1:0] r_mem [CAPACITY];
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_hold;
    logic [WORD_W-1:0] r_val;
    logic [MODE_W-1:0] r_mode;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  r_cur;
    logic [CNT_W-1:0]  r_pend_idx;
    logic              r_pend;
    logic              r_ovalid;
    logic [INDEX_W-1:0]  r_oindex;
    logic [WORD_W-1:0]   r_oelem;
    logic                r_olast;
    logic [STATUS_W-1:0] r_ostatus;

    logic [CW-1:0]    pos_ext;
    logic [CW-1:0]    used_ext;
    logic [CW-1:0]    i_ext;
    logic [CNT_W-1:0] i_m1;
    logic [CNT_W-1:0] i_p1;
    logic [LW-1:0]    pend_ext;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic             can_load;
    logic             list_load;
    logic             list_issue;
    logic             more;
    logic             rd_en;

    assign pos_ext  = CW'(r_pos);
    assign used_ext = CW'(r_used);
    assign i_ext    = CW'(r_i);
    assign i_m1     = r_i - 1'b1;
    assign i_p1     = r_i + 1'b1;
    assign pend_ext = LW'(r_pend_idx);

    function automatic logic [AW-1:0] sel_addr(
        input t_asel            sel,
        input logic [CNT_W-1:0] i_v,
        input logic [CNT_W-1:0] im1,
        input logic [CNT_W-1:0] ip1,
        input logic [CNT_W-1:0] j_v,
        input logic [CNT_W-1:0] used,
        input logic [CW-1:0]    pos
    );
        logic [AW-1:0] a;
        case (sel)
            AS_I:    a = i_v[AW-1:0];
            AS_IM1:  a = im1[AW-1:0];
            AS_IP1:  a = ip1[AW-1:0];
            AS_J:    a = j_v[AW-1:0];
            AS_USED: a = used[AW-1:0];
            AS_POS:  a = pos[AW-1:0];
            default: a = i_v[AW-1:0];
        endcase
        return a;
    endfunction

    // listing stream: one read in flight, output register as the sink
    assign can_load   = !r_ovalid || !i_stall;
    assign list_load  = i_cmd.list_run && r_pend && can_load;
    assign more       = (r_cur < r_used);
    assign list_issue = i_cmd.list_run && more && (!r_pend || list_load);
    assign rd_en      = i_cmd.rd_en || list_issue;

    always_comb begin
        if (i_cmd.list_run) begin
            rd_addr = r_cur[AW-1:0];
        end else begin
            rd_addr = sel_addr(i_cmd.rd_sel, r_i, i_m1, i_p1, r_j, r_used, pos_ext);
        end
        wr_addr = sel_addr(i_cmd.wr_sel, r_i, i_m1, i_p1, r_j, r_used, pos_ext);
        case (i_cmd.wr_dsel)
            DS_VAL:   wr_data = r_val;
            DS_RDATA: wr_data = r_rdata;
            DS_HOLD:  wr_data = r_hold;
            default:  wr_data = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_mode <= i_mode;
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        if (i_cmd.hold_ld) begin
            r_hold <= r_rdata;
        end
        case (i_cmd.i_op)
            PO_USED: r_i <= r_used;
            PO_POS:  r_i <= pos_ext[CNT_W-1:0];
            PO_ZERO: r_i <= '0;
            PO_INC:  r_i <= i_p1;
            PO_DEC:  r_i <= i_m1;
            default: r_i <= r_i;
        endcase
        if (i_cmd.j_init) begin
            r_j <= r_used - 1'b1;
        end else if (i_cmd.j_dec) begin
            r_j <= r_j - 1'b1;
        end
        if (list_issue) begin
            r_pend_idx <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_cur  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.used_inc) begin
                r_used <= r_used + 1'b1;
            end else if (i_cmd.used_dec) begin
                r_used <= r_used - 1'b1;
            end
            if (i_cmd.list_start) begin
                r_cur  <= '0;
                r_pend <= 1'b0;
            end else begin
                if (list_issue) begin
                    r_cur <= r_cur + 1'b1;
                end
                if (list_issue) begin
                    r_pend <= 1'b1;
                end else if (list_load) begin
                    r_pend <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (list_load || i_cmd.stat_ld) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (list_load) begin
            r_oindex  <= pend_ext[INDEX_W-1:0];
            r_oelem   <= r_rdata;
            r_olast   <= (CNT_W'(r_pend_idx + 1'b1) == r_used);
            r_ostatus <= ST_OK;
        end else if (i_cmd.stat_ld) begin
            r_oindex  <= '0;
            r_oelem   <= '0;
            r_olast   <= 1'b1;
            r_ostatus <= i_cmd.stat_code;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_index   = r_oindex;
    assign o_element = r_oelem;
    assign o_last    = r_olast;
    assign o_status  = r_ostatus;

    always_comb begin
        o_sts.mode        = r_mode;
        o_sts.full        = (r_used >= CNT_W'(CAPACITY));
        o_sts.empty       = (r_used == '0);
        o_sts.pos_gt_used = (pos_ext > used_ext);
        o_sts.pos_ge_used = (pos_ext >= used_ext);
        o_sts.i_gt_pos    = (i_ext > pos_ext);
        o_sts.ip1_lt_used = (i_p1 < r_used);
        o_sts.i_lt_j      = (r_i < r_j);
        o_sts.out_free    = can_load;
        o_sts.list_done   = i_cmd.list_run && !more && !r_pend;
    end

endmodule
`default_nettype wire

// ===== rtl/positional_array_edit_engine_core.sv =====
// positional array edit engine
// input channel: i_valid / o_stall with i_mode, i_position, i_value; a beat is
// taken when i_valid is high and o_stall is low. one edit is worked at a time,
// o_stall stays high from the accepted beat until the edit has finished.
// output channel: o_valid / i_stall with o_index, o_element, o_last, o_status.
// insert, delete, reverse and update list the whole used array, one beat per
// word, o_last on the final one. append gives no beat. a rejected edit gives a
// single status beat with index and element at zero and o_last set.
// an insert or delete shifts the word memory one word at a time, a read then a
// write per moved word; a reverse swaps pairs with two reads then two writes.
// the listing then streams one beat per cycle, while the receiver does not
// stall, from the memory's single read port.
// when the receiver stalls, the output register holds its beat and the listing
// pauses with it; nothing is dropped.
// reset clears the word count and all control; the word store itself is not
// cleared, and only entries below the count are ever read.
`default_nettype none
module positional_array_edit_engine_core
    import pae_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [WORD_W-1:0] i_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [INDEX_W-1:0]            o_index,
    output logic signed [WORD_W-1:0]      o_element,
    output logic                          o_last,
    output logic [STATUS_W-1:0]           o_status
);

    t_cmd cmd;
    t_sts sts;

    pae_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pae_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_mode     (i_mode),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_index    (o_index),
        .o_element  (o_element),
        .o_last     (o_last),
        .o_status   (o_status)
    );

endmodule
`default_nettype wire
